FILE: rtl/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Shared codes and constants for the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam logic [63:0] HashMult = 64'd3197;

  localparam logic [1:0] ModePut    = 2'd0;
  localparam logic [1:0] ModeGet    = 2'd1;
  localparam logic [1:0] ModeRemove = 2'd2;

  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StUpdated  = 3'd1;
  localparam logic [2:0] StFound    = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  localparam logic [7:0] MaxEntriesReset = 8'd128;

endpackage

FILE: rtl/lph_mem.sv
// ----------------------------------------------------------------------------
// lph_mem
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lph_mem #(
  parameter int DEPTH = 256,
  parameter int W     = 65
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lph_hash.sv
// ----------------------------------------------------------------------------
// lph_hash
// Home slot unit: (3197 * key) mod SLOTS, product kept to 64 bits.
// Power-of-two table sizes take a mask, other sizes a reciprocal reduction
// of the product in four 16-bit digits, each by estimate, subtract and fix.
// ----------------------------------------------------------------------------
module lph_hash #(
  parameter int SLOTS    = 256,
  parameter int KEY_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [KEY_BITS-1:0]      key,
  output logic                     done,
  output logic [$clog2(SLOTS)-1:0] slot
);

  localparam int AW = $clog2(SLOTS);
  localparam bit IsPow2 = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [31:0] Mu   = 32'((64'd1 << 32) / 64'(SLOTS));
  localparam logic [31:0] Mod  = 32'(SLOTS);
  localparam logic [16:0] ModR = 17'(SLOTS);

  typedef enum logic [1:0] {
    P_EST, P_SUB, P_FIX
  } phase_t;

  logic          run_r;
  logic          done_r;
  logic [63:0]   prod_r;
  phase_t        ph_r;
  logic [1:0]    dig_r;
  logic [15:0]   q_r;
  logic [16:0]   r_r;
  logic [AW-1:0] rem_r;
  logic [31:0]   part;
  logic [63:0]   part_mu;
  logic [31:0]   q_mod;

  // partial remainder with the next digit shifted in
  assign part    = {16'(rem_r), prod_r[63:48]};
  assign part_mu = 64'(part) * 64'(Mu);
  assign q_mod   = 32'(q_r) * Mod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        prod_r <= 64'(64'(key) * lph_pkg::HashMult);
        rem_r  <= '0;
        dig_r  <= '0;
        ph_r   <= P_EST;
        run_r  <= 1'b1;
      end else if (run_r) begin
        if (IsPow2) begin
          rem_r  <= prod_r[AW-1:0];
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          unique case (ph_r)
            P_EST: begin
              q_r  <= part_mu[47:32];
              ph_r <= P_SUB;
            end
            P_SUB: begin
              r_r  <= 17'(part - q_mod);
              ph_r <= P_FIX;
            end
            P_FIX: begin
              rem_r  <= AW'((r_r >= ModR) ? r_r - ModR : r_r);
              prod_r <= {prod_r[47:0], 16'd0};
              dig_r  <= dig_r + 2'd1;
              ph_r   <= P_EST;
              if (dig_r == 2'd3) begin
                run_r  <= 1'b0;
                done_r <= 1'b1;
              end
            end
            default: begin
              ph_r <= P_EST;
            end
          endcase
        end
      end
    end
  end

  assign done = done_r;
  assign slot = rem_r;

endmodule

FILE: rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing key/value table, linear probing, backward-shift delete.
// ----------------------------------------------------------------------------
// After reset a clearing pass writes every slot, with busy high.
// An operation hashes the key (a mask when SLOTS is a power of two, a
// reciprocal reduction otherwise), then probes slot by slot through the
// single read port of the slot memory; a remove rehashes each entry walked
// past the hole and clears the last hole. One operation at a time, results
// cannot be held off; busy falls in the cycle the out_valid pulse shows.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int SLOTS      = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_mode,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [VALUE_BITS-1:0] out_value_out,
  output logic [8:0]            out_entries,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);

  localparam int AW = $clog2(SLOTS);
  localparam int W  = 1 + KEY_BITS + VALUE_BITS;
  localparam logic [AW-1:0] LastSlot = AW'(SLOTS - 1);
  localparam logic [AW:0]   SlotsN   = (AW + 1)'(SLOTS);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HASH, S_FRD, S_FCHK, S_SRD, S_SDAT, S_SHASH, S_SEND
  } state_t;

  state_t                state_r;
  logic [AW-1:0]         clr_r;
  logic [AW-1:0]         probe_r;
  logic [AW:0]           n_r;
  logic [AW-1:0]         hole_r;
  logic [AW-1:0]         pos_r;
  logic [1:0]            mode_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [KEY_BITS-1:0]   ent_key_r;
  logic [VALUE_BITS-1:0] ent_val_r;
  logic [8:0]            count_r;
  logic [7:0]            max_r;
  logic                  out_valid_r;
  logic [2:0]            out_status_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic [8:0]            out_entries_r;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [W-1:0]          wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [W-1:0]          rd_data;

  logic                  rd_used;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  match;
  logic                  full;
  logic                  put_wr;
  logic                  accept;

  logic                  h_start;
  logic [KEY_BITS-1:0]   h_key;
  logic                  h_done;
  logic [AW-1:0]         h_slot;

  logic [AW:0]           home_dist;
  logic [AW:0]           delta;
  logic                  stay;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a);
    next_slot = (a == LastSlot) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW:0] wrap_diff(input logic [AW-1:0] a,
                                            input logic [AW-1:0] b);
    wrap_diff = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + SlotsN - {1'b0, b};
  endfunction

  assign rd_used = rd_data[W-1];
  assign rd_key  = rd_data[W-2 -: KEY_BITS];
  assign rd_val  = rd_data[VALUE_BITS-1:0];
  assign match   = rd_used && (rd_key == key_r);
  assign full    = count_r >= {1'b0, max_r};
  assign put_wr  = (mode_r == lph_pkg::ModePut) && (match || (!rd_used && !full));
  assign accept  = start && (state_r == S_IDLE);

  assign home_dist = wrap_diff(h_slot, hole_r);
  assign delta     = wrap_diff(pos_r, hole_r);
  assign stay      = (home_dist != '0) && (home_dist <= delta);

  assign h_start = accept || ((state_r == S_SDAT) && rd_used);
  assign h_key   = (state_r == S_IDLE) ? in_key : rd_key;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hole_r;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = pos_r;
    unique case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
      end
      S_FRD: begin
        rd_en   = 1'b1;
        rd_addr = probe_r;
      end
      S_FCHK: begin
        wr_en   = put_wr;
        wr_addr = probe_r;
        wr_data = {1'b1, key_r, val_r};
      end
      S_SRD: begin
        rd_en = (n_r != SlotsN) && (pos_r != hole_r);
      end
      S_SHASH: begin
        wr_en   = h_done && !stay;
        wr_data = {1'b1, ent_key_r, ent_val_r};
      end
      S_SEND: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == LastSlot) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            mode_r  <= in_mode;
            key_r   <= in_key;
            val_r   <= in_value;
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          if (h_done) begin
            probe_r <= h_slot;
            n_r     <= '0;
            state_r <= S_FRD;
          end
        end
        S_FRD: begin
          state_r <= S_FCHK;
        end
        S_FCHK: begin
          out_value_r   <= '0;
          out_entries_r <= count_r;
          if (match) begin
            if (mode_r == lph_pkg::ModeRemove) begin
              out_value_r <= rd_val;
              count_r     <= count_r - 9'd1;
              hole_r      <= probe_r;
              pos_r       <= next_slot(probe_r);
              n_r         <= '0;
              state_r     <= S_SRD;
            end else begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
              priority if (mode_r == lph_pkg::ModePut) begin
                out_status_r <= lph_pkg::StUpdated;
              end else if (mode_r == lph_pkg::ModeGet) begin
                out_status_r <= lph_pkg::StFound;
                out_value_r  <= rd_val;
              end else begin
                out_status_r <= lph_pkg::StNotFound;
              end
            end
          end else if (!rd_used || (n_r + (AW + 1)'(1) == SlotsN)) begin
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
            out_status_r <= lph_pkg::StNotFound;
            if (mode_r == lph_pkg::ModePut) begin
              if (put_wr) begin
                out_status_r  <= lph_pkg::StInserted;
                count_r       <= count_r + 9'd1;
                out_entries_r <= count_r + 9'd1;
              end else begin
                out_status_r <= lph_pkg::StFull;
              end
            end
          end else begin
            probe_r <= next_slot(probe_r);
            n_r     <= n_r + (AW + 1)'(1);
            state_r <= S_FRD;
          end
        end
        S_SRD: begin
          state_r <= rd_en ? S_SDAT : S_SEND;
        end
        S_SDAT: begin
          ent_key_r <= rd_key;
          ent_val_r <= rd_val;
          state_r   <= rd_used ? S_SHASH : S_SEND;
        end
        S_SHASH: begin
          if (h_done) begin
            if (!stay) begin
              hole_r <= pos_r;
            end
            pos_r   <= next_slot(pos_r);
            n_r     <= n_r + (AW + 1)'(1);
            state_r <= S_SRD;
          end
        end
        S_SEND: begin
          out_valid_r   <= 1'b1;
          out_status_r  <= lph_pkg::StFound;
          out_entries_r <= count_r;
          state_r       <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= lph_pkg::MaxEntriesReset;
    end else if (cfg_valid && cfg_ready) begin
      max_r <= cfg_data;
    end
  end

  lph_hash #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (h_start),
    .key   (h_key),
    .done  (h_done),
    .slot  (h_slot)
  );

  lph_mem #(
    .DEPTH (SLOTS),
    .W     (W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy          = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;
  assign out_entries   = out_entries_r;

  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    !count_r[8])
    else $error("entry count beyond register range");

  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !out_valid_r)
    else $error("result during clearing pass");

  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> busy)
    else $error("memory write while idle");

endmodule

FILE: tb/tb_linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Drives put, get and remove commands with bursty timing and collision-heavy
// key sets through several entry limits. A software image of the probed table
// with backward-shift delete predicts every status, value and entry count.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;

  localparam logic [1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
    logic [8:0]  entries;
  } hash_result_t;

  function automatic logic [7:0] home_of(logic [31:0] k);
    logic [63:0] p;
    p = lph_pkg::HashMult * {32'd0, k};
    return p[7:0];
  endfunction

  class hash_scoreboard;
    logic [31:0]  slot_key[256];
    logic [31:0]  slot_val[256];
    bit           slot_used[256];
    int           count;
    logic [7:0]   max_entries;
    int           errors;
    hash_result_t pending[$];

    function new();
      foreach (slot_used[i]) slot_used[i] = 0;
      count = 0;
      max_entries = lph_pkg::MaxEntriesReset;
      errors = 0;
    endfunction

    function int lookup(logic [31:0] k);
      int i;
      i = home_of(k);
      for (int n = 0; n < 256 && slot_used[i]; n++) begin
        if (slot_key[i] == k) return i;
        i = (i + 1) % 256;
      end
      return -1;
    endfunction

    function void shift_back(int hole);
      int pos, home_dist, delta;
      pos = (hole + 1) % 256;
      for (int n = 0; n < 256 && slot_used[pos]; n++) begin
        home_dist = (home_of(slot_key[pos]) + 256 - hole) % 256;
        delta = (pos + 256 - hole) % 256;
        if (!(home_dist > 0 && home_dist <= delta)) begin
          slot_key[hole] = slot_key[pos];
          slot_val[hole] = slot_val[pos];
          slot_used[hole] = 1;
          slot_used[pos] = 0;
          hole = pos;
        end
        pos = (pos + 1) % 256;
      end
    endfunction

    function void note_command(logic [1:0] mode, logic [31:0] k, logic [31:0] v);
      hash_result_t r;
      int at, i, n;
      r.status = lph_pkg::StNotFound;
      r.value = '0;
      at = lookup(k);
      case (mode)
        lph_pkg::ModePut: begin
          if (at >= 0) begin
            slot_val[at] = v;
            r.status = lph_pkg::StUpdated;
          end else if (count >= max_entries) begin
            r.status = lph_pkg::StFull;
          end else begin
            i = home_of(k);
            for (n = 0; n < 256 && slot_used[i]; n++) i = (i + 1) % 256;
            if (slot_used[i]) begin
              r.status = lph_pkg::StFull;
            end else begin
              slot_key[i] = k;
              slot_val[i] = v;
              slot_used[i] = 1;
              count++;
              r.status = lph_pkg::StInserted;
            end
          end
        end
        lph_pkg::ModeGet: begin
          if (at >= 0) begin
            r.value = slot_val[at];
            r.status = lph_pkg::StFound;
          end
        end
        lph_pkg::ModeRemove: begin
          if (at >= 0) begin
            r.value = slot_val[at];
            slot_used[at] = 0;
            if (count > 0) count--;
            shift_back(at);
            r.status = lph_pkg::StFound;
          end
        end
        default: ;
      endcase
      r.entries = count[8:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] v, logic [8:0] ent);
      hash_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h entries=%0d", $time, st, v, ent);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (v !== e.value) begin
        $display("%0t: value_out expected %h actual %h", $time, e.value, v);
        errors++;
      end
      if (ent !== e.entries) begin
        $display("%0t: entries expected %0d actual %0d", $time, e.entries, ent);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [31:0] in_key;
  logic [31:0] in_value;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_value_out;
  logic [8:0]  out_entries;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  hash_scoreboard sb = new();
  logic [31:0] key_pool[48];
  int burst_left;

  linear_probe_hash_table u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_key(in_key), .in_value(in_value),
    .out_valid(out_valid), .out_status(out_status),
    .out_value_out(out_value_out), .out_entries(out_entries),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #64_000_000;
    $display("tb_linear_probe_hash_table: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_value_out, out_entries);
  end

  function automatic logic [31:0] key_at_home(logic [7:0] h);
    for (int lb = 0; lb < 256; lb++)
      if (home_of(lb) == h) return {$urandom() & 32'hffffff00} | lb;
    return '0;
  endfunction

  task automatic send_command(logic [1:0] mode, logic [31:0] k, logic [31:0] v);
    start <= 1'b1;
    in_mode <= mode;
    in_key <= k;
    in_value <= v;
    do @(posedge clk); while (busy);
    sb.note_command(mode, k, v);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.max_entries = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int n, int put_pct, int remove_pct);
    logic [1:0] mode;
    logic [31:0] k;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) mode = ModeUnused;
      else if (r < 2 + put_pct) mode = lph_pkg::ModePut;
      else if (r < 2 + put_pct + remove_pct) mode = lph_pkg::ModeRemove;
      else mode = lph_pkg::ModeGet;
      r = $urandom_range(0, 99);
      if (r < 70) k = key_pool[$urandom_range(0, 47)];
      else if (r < 85) k = key_pool[$urandom_range(0, 47)] ^ ($urandom() & 32'hffffff00);
      else k = $urandom();
      send_command(mode, k, $urandom());
    end
  endtask

  initial begin
    logic [31:0] w0, w1, w2;
    rst_n = 0;
    start = 0;
    in_mode = lph_pkg::ModePut;
    in_key = '0;
    in_value = '0;
    cfg_valid = 0;
    cfg_data = '0;
    burst_left = 0;
    foreach (key_pool[i]) begin
      case (i % 4)
        0: key_pool[i] = key_at_home(8'hff);
        1: key_pool[i] = key_at_home(8'h00);
        2: key_pool[i] = key_at_home(8'h80 + i[2:0]);
        default: key_pool[i] = $urandom();
      endcase
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, update, wrap-around cluster and shift-back
    send_command(lph_pkg::ModePut, 32'h0, 32'h0);
    send_command(lph_pkg::ModePut, 32'hffffffff, 32'hffffffff);
    send_command(lph_pkg::ModeGet, 32'h0, 32'h0);
    send_command(lph_pkg::ModeGet, 32'hffffffff, 32'h0);
    send_command(lph_pkg::ModePut, 32'h0, 32'ha5a5a5a5);
    w0 = key_at_home(8'hff);
    w1 = key_at_home(8'hff) ^ 32'h100;
    w2 = key_at_home(8'hfe);
    send_command(lph_pkg::ModePut, w0, 32'h1);
    send_command(lph_pkg::ModePut, w1, 32'h2);
    send_command(lph_pkg::ModePut, w2, 32'h3);
    send_command(lph_pkg::ModeRemove, w0, 32'hffffffff);
    send_command(lph_pkg::ModeGet, w1, 32'h0);
    send_command(lph_pkg::ModeGet, w2, 32'h0);
    send_command(lph_pkg::ModeGet, w0, 32'h0);
    send_command(lph_pkg::ModeRemove, w0, 32'h0);
    send_command(ModeUnused, w1, 32'hffffffff);
    send_command(lph_pkg::ModeRemove, 32'h0, 32'h0);
    send_command(lph_pkg::ModeGet, 32'h0, 32'h0);

    write_limit(8'd1);
    send_command(lph_pkg::ModePut, w0, 32'h5);
    send_command(lph_pkg::ModePut, w1, 32'h6);
    run_random(60, 45, 20);

    write_limit(8'd255);
    run_random(330, 75, 5);
    run_random(150, 20, 40);

    write_limit(8'd40);
    run_random(180, 45, 25);

    write_limit(8'd200);
    run_random(150, 40, 25);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_linear_probe_hash_table: PASS");
    end else begin
      $display("tb_linear_probe_hash_table: FAIL");
    end
    $finish;
  end
endmodule
